/* rtl/tcr_pkg.sv */
// Torque command ramp: shared types and constants.
// Used by every module of the block; depends on nothing.
package tcr_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_COEF     = 3'd0;
  localparam logic [2:0] REG_POS_LIM  = 3'd1;
  localparam logic [2:0] REG_NEG_LIM  = 3'd2;
  localparam logic [2:0] REG_FREQ     = 3'd3;
  localparam logic [2:0] REG_SLOPE    = 3'd4;
  localparam logic [2:0] REG_OP_MODE  = 3'd5;
  localparam logic [2:0] REG_POLARITY = 3'd6;

  localparam int IN_W     = 40;  // input tdata width
  localparam int OUT_W    = 24;  // output tdata width
  localparam int TGT_W    = 22;  // scaled target, signed
  localparam int CMD_W    = 34;  // target in Q12, signed
  localparam int REF_W    = 36;  // ramp reference in Q12, signed
  localparam int DVD_W    = 48;  // coefficient times slope
  localparam int STEP_W   = 33;  // ramp step magnitude
  localparam int FRAC_W   = 12;  // Q12 fraction bits

  typedef struct packed {
    logic [15:0]        coef;
    logic [14:0]        pos_lim;
    logic signed [15:0] neg_lim;
    logic [15:0]        freq;
    logic [31:0]        slope;
    logic               cyclic;
    logic               polarity;
  } cfg_t;

  // One classified tick between front and back
  typedef struct packed {
    logic signed [TGT_W-1:0] target;
    logic                    running;
    logic                    enabled;
    logic                    switching;
    logic                    stop;
  } entry_t;

endpackage

/* rtl/tcr_fifo.sv */
// Torque command ramp: short queue between front and back.
// Depends on tcr_pkg.
module tcr_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tcr_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output tcr_pkg::entry_t pop_data,
  output logic            empty
);
  import tcr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push && !full) - CNT_W'(pop && !empty);
    end
  end

endmodule

/* rtl/tcr_front.sv */
// Torque command ramp: front end. Takes input transfers and forms the scaled,
// sign-corrected target. Depends on tcr_pkg.
module tcr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  tcr_pkg::cfg_t              cfg,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [tcr_pkg::IN_W-1:0]   s_tdata,
  output logic                       push,
  output tcr_pkg::entry_t            push_data,
  input  logic                       full
);
  import tcr_pkg::*;

  logic [IN_W-1:0]     item;
  logic                item_valid;
  logic signed [15:0]  tgt_in;
  logic signed [15:0]  off_in;
  logic signed [16:0]  base;
  logic signed [33:0]  prod;
  logic signed [TGT_W-1:0] scaled;
  logic                active;

  assign push     = item_valid && !full;
  assign s_tready = !item_valid || push;

  // holding register for one accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= s_tdata;
    end
  end

  // target: cyclic offset, gain, floor to integer, polarity and direction flips
  always_comb begin
    tgt_in = item[15:0];
    off_in = item[31:16];
    base   = cfg.cyclic ? (17'(tgt_in) + 17'(off_in)) : 17'(tgt_in);
    prod   = $signed({18'd0, cfg.coef}) * 34'(base);
    scaled = TGT_W'(prod >>> FRAC_W);
    active = item[32] && !item[33];
    push_data.target    = '0;
    if (active) begin
      push_data.target = (cfg.polarity ^ item[34]) ? -scaled : scaled;
    end
    push_data.enabled   = item[32];
    push_data.switching = item[33];
    push_data.running   = item[35];
    push_data.stop      = item[36];
  end

endmodule

/* rtl/tcr_div.sv */
// Torque command ramp: restoring divider, one quotient bit per cycle.
// Depends on tcr_pkg.
module tcr_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tcr_pkg::DVD_W-1:0]  dividend,
  input  logic [15:0]                divisor,
  output logic                       done,
  output logic [tcr_pkg::DVD_W-1:0]  quotient
);
  import tcr_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [15:0]       rem;
  logic [DVD_W-1:0]  shreg;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [16:0]       trial;
  logic              fits;

  assign trial    = {rem, shreg[DVD_W-1]};
  assign fits     = (trial >= {1'b0, divisor});
  assign quotient = shreg;

  // iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
    end else if (busy) begin
      rem   <= fits ? 16'(trial - {1'b0, divisor}) : trial[15:0];
      shreg <= {shreg[DVD_W-2:0], fits};
    end
  end

endmodule

/* rtl/tcr_back.sv */
// Torque command ramp: back end. Step limits, slope division, reference
// update and output register. Depends on tcr_pkg and tcr_div.
module tcr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  tcr_pkg::cfg_t               cfg,
  input  logic                        empty,
  input  tcr_pkg::entry_t             pop_data,
  output logic                        pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [tcr_pkg::OUT_W-1:0]   m_tdata
);
  import tcr_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LIM  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;

  logic [2:0]              state;
  logic [2:0]              state_next;
  entry_t                  e;
  logic signed [REF_W-1:0] ramp_ref;
  logic signed [CMD_W-1:0] cmd;
  logic                    fast;
  logic [15:0]             lim_f;
  logic [15:0]             lim_b;
  logic [31:0]             pfreq;
  logic [31:0]             nfreq;
  logic [DVD_W-1:0]        dvd;
  logic [31:0]             mul_f;
  logic [31:0]             mul_b;
  logic                    cmp_p;
  logic                    cmp_n;
  logic                    div_start;
  logic                    div_done;
  logic [DVD_W-1:0]        quot;
  logic                    slot_free;

  // limit stage signals
  logic [15:0]             freq;
  logic [31:0]             slope;
  logic [15:0]             nmax;
  logic [14:0]             lim_pos;
  logic [15:0]             lim_neg;
  logic signed [TGT_W:0]   neg_t;
  logic                    fast_c;

  // update stage signals
  logic [STEP_W-1:0]       fwd;
  logic [STEP_W-1:0]       bwd;
  logic signed [37:0]      r_x;
  logic signed [37:0]      c_x;
  logic signed [37:0]      t;
  logic signed [37:0]      nr;

  assign slot_free = !m_tvalid || m_tready;
  assign pop       = (state == ST_IDLE) && !empty;

  tcr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (freq),
    .done     (div_done),
    .quotient (quot)
  );

  // limits from the torque limits and the target
  always_comb begin
    freq    = (cfg.freq == '0) ? 16'd1 : cfg.freq;
    slope   = (cfg.slope == '0) ? 32'd1 : cfg.slope;
    nmax    = (cfg.neg_lim > 0) ? 16'd0 : 16'(-17'(cfg.neg_lim));
    neg_t   = -(TGT_W+1)'(e.target);
    lim_pos = cfg.pos_lim;
    if (e.target > 0 && e.target < $signed({7'd0, cfg.pos_lim})) begin
      lim_pos = e.target[14:0];
    end
    lim_neg = nmax;
    if (e.target < 0 && neg_t < $signed({7'd0, nmax})) begin
      lim_neg = neg_t[15:0];
    end
    fast_c    = cfg.cyclic && !e.stop && !e.switching;
    div_start = (state == ST_MUL) && !fast && ((slope <= pfreq) || (slope <= nfreq));
  end

  // reference update, no overshoot, zero on crossing or when not running
  always_comb begin
    fwd = (fast || cmp_p) ? STEP_W'(mul_f) : quot[STEP_W-1:0];
    bwd = (fast || cmp_n) ? STEP_W'(mul_b) : quot[STEP_W-1:0];
    r_x = 38'(ramp_ref);
    c_x = 38'(cmd);
    if (r_x < c_x) begin
      if (r_x >= 0) begin
        t = r_x + $signed({5'd0, fwd});
      end else begin
        t = r_x + $signed({5'd0, bwd});
        if (t >= 0 && e.target >= 0) begin
          t = '0;
        end
      end
      nr = (t < c_x) ? t : c_x;
    end else begin
      if (r_x > 0) begin
        t = r_x - $signed({5'd0, fwd});
        if (t <= 0 && e.target <= 0) begin
          t = '0;
        end
      end else begin
        t = r_x - $signed({5'd0, bwd});
      end
      nr = (t > c_x) ? t : c_x;
    end
    if (!e.running) begin
      nr = '0;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!empty) state_next = ST_LIM;
      ST_LIM:  state_next = e.running ? ST_MUL : ST_UPD;
      ST_MUL:  state_next = div_start ? ST_DIV : ST_UPD;
      ST_DIV:  if (div_done) state_next = ST_UPD;
      ST_UPD:  if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ramp_ref <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_UPD && slot_free) begin
        ramp_ref <= REF_W'(nr);
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      e <= pop_data;
    end
    if (state == ST_LIM) begin
      cmd   <= CMD_W'(e.target) <<< FRAC_W;
      fast  <= fast_c;
      lim_f <= fast_c ? {1'b0, lim_pos} : {1'b0, cfg.pos_lim};
      lim_b <= fast_c ? lim_neg : nmax;
      pfreq <= 32'({1'b0, cfg.pos_lim}) * 32'(freq);
      nfreq <= nmax * freq;
      dvd   <= DVD_W'(cfg.coef) * DVD_W'(slope);
    end
    if (state == ST_MUL) begin
      mul_f <= cfg.coef * lim_f;
      mul_b <= cfg.coef * lim_b;
    end
    if (state == ST_LIM) begin
      cmp_p <= 1'b0;
      cmp_n <= 1'b0;
    end else if (state == ST_MUL) begin
      cmp_p <= (slope > pfreq);
      cmp_n <= (slope > nfreq);
    end
    if (state == ST_UPD && slot_free) begin
      m_tdata <= {2'b00, e.running && cfg.cyclic && e.enabled, nr[32:12]};
    end
  end

endmodule

/* rtl/torque_command_ramp.sv */
// Torque command ramp: top level with configuration registers.
// Depends on tcr_pkg, tcr_front, tcr_fifo and tcr_back.
//
// One input transfer is one torque-loop tick and gives exactly one output
// transfer. When the slope ramp is in use (profile mode, stop or mode switch,
// with the slope not above both limits times the frequency) the back end runs
// the 48-bit restoring divider for slope/frequency in a divide state. The front
// end and a QUEUE_DEPTH entry queue take further ticks while the back end works
// or the output waits. Configuration is to be written with
// cfg_we/cfg_addr/cfg_wdata only while idle; the block does not enforce this.
module torque_command_ramp #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] target_torque, [31:16] torque_offset, [32] op_enabled,
  // [33] mode_switching, [34] dir_select, [35] servo_running,
  // [36] stop_active, [39:37] zero
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [20:0] torque_ref, [21] cst_following, [23:22] zero
  output logic [23:0] m_tdata
);
  import tcr_pkg::*;

  cfg_t   cfg;
  logic   push;
  entry_t push_data;
  logic   full;
  logic   pop;
  entry_t pop_data;
  logic   empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef     <= 16'd4096;
      cfg.pos_lim  <= 15'd3000;
      cfg.neg_lim  <= -16'sd3000;
      cfg.freq     <= 16'd16000;
      cfg.slope    <= 32'd0;
      cfg.cyclic   <= 1'b0;
      cfg.polarity <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COEF:     cfg.coef     <= cfg_wdata[15:0];
        REG_POS_LIM:  cfg.pos_lim  <= cfg_wdata[14:0];
        REG_NEG_LIM:  cfg.neg_lim  <= cfg_wdata[15:0];
        REG_FREQ:     cfg.freq     <= cfg_wdata[15:0];
        REG_SLOPE:    cfg.slope    <= cfg_wdata;
        REG_OP_MODE:  cfg.cyclic   <= cfg_wdata[0];
        REG_POLARITY: cfg.polarity <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  tcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  tcr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  tcr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* rtl/tcr_checker.sv */
// Torque command ramp: port-level checks, bound to the top level.
// Depends on tcr_pkg.
module tcr_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [2:0]  cfg_addr,
  input logic [31:0] cfg_wdata,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);
  import tcr_pkg::*;

  logic        cyclic;
  logic [7:0]  pending;

  // shadow of the mode bit and count of outstanding ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      cyclic  <= 1'b0;
      pending <= '0;
    end else begin
      if (cfg_we && cfg_addr == REG_OP_MODE) begin
        cyclic <= cfg_wdata[0];
      end
      pending <= pending + 8'(s_tvalid && s_tready) - 8'(m_tvalid && m_tready);
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output changed");

  a_profile_follow: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !cyclic |-> !m_tdata[21])
    else $error("following flag set in profile mode");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pending != '0) || (s_tvalid && s_tready && 1'b0))
    else $error("output without an outstanding tick");

endmodule

bind torque_command_ramp tcr_checker u_tcr_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .cfg_addr  (cfg_addr),
  .cfg_wdata (cfg_wdata),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);

/* test/testbench.sv */
// Testbench for torque_command_ramp: directed and random ticks checked against
// an in-bench model of the torque ramp. Depends on tcr_pkg and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tcr_pkg::*;

  localparam longint CYCLE_LIMIT = 800000;
  localparam int     LONG_HOLD   = 400;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  typedef struct packed {
    logic               stop;
    logic               running;
    logic               dirsel;
    logic               switching;
    logic               enabled;
    logic signed [15:0] offset;
    logic signed [15:0] target;
  } tick_t;

  typedef struct packed {
    logic               follow;
    logic signed [20:0] ref_int;
  } torque_out_t;

  torque_command_ramp dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Model copy of the registers and the ramp state
  logic [15:0]        coef_r;
  logic [14:0]        pos_lim_r;
  logic signed [15:0] neg_lim_r;
  logic [15:0]        freq_r;
  logic [31:0]        slope_r;
  logic               cyclic_r;
  logic               polarity_r;
  longint             ramp_q12;

  torque_out_t expected_refs[$];
  int     mismatches = 0;
  bit     sender_idle_en;
  bit     receiver_idle_en;
  int     hold_off = 0;
  int     long_hold_req = 0;
  int     long_hold_seen = 0;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_q12(longint v);
    if (v >= 0) return v >>> 12;
    return -((-v + 4095) >>> 12);
  endfunction

  // Advance the ramp one tick and queue the expected output
  function automatic void predict_tick(tick_t t);
    longint tgt, cmd, pmax, nmax, fq, sl, lp, ln, fwd, bwd, nx, c;
    torque_out_t o;
    c = coef_r;
    tgt = 0;
    o.follow = 1'b0;
    if (t.enabled && !t.switching) begin
      tgt = floor_q12(c * (cyclic_r ? longint'(t.target) + longint'(t.offset)
                                    : longint'(t.target)));
      if (polarity_r) tgt = -tgt;
      if (t.dirsel) tgt = -tgt;
    end
    if (t.running) begin
      cmd = tgt * 4096;
      if (ramp_q12 != cmd) begin
        pmax = pos_lim_r;
        nmax = -longint'(neg_lim_r);
        if (nmax < 0) nmax = 0;
        fq = freq_r ? freq_r : 1;
        sl = slope_r ? slope_r : 1;
        lp = pmax;
        ln = nmax;
        if (tgt > 0 && tgt < pmax) lp = tgt;
        if (tgt < 0 && -tgt < nmax) ln = -tgt;
        if (cyclic_r && !t.stop && !t.switching) begin
          fwd = c * lp;
          bwd = c * ln;
        end else begin
          fwd = (sl > pmax * fq) ? c * pmax : (c * sl) / fq;
          bwd = (sl > nmax * fq) ? c * nmax : (c * sl) / fq;
        end
        if (ramp_q12 < cmd) begin
          if (ramp_q12 >= 0) nx = ramp_q12 + fwd;
          else begin
            nx = ramp_q12 + bwd;
            if (nx >= 0 && tgt >= 0) nx = 0;
          end
          ramp_q12 = (nx < cmd) ? nx : cmd;
        end else begin
          if (ramp_q12 > 0) begin
            nx = ramp_q12 - fwd;
            if (nx <= 0 && tgt <= 0) nx = 0;
          end else nx = ramp_q12 - bwd;
          ramp_q12 = (nx > cmd) ? nx : cmd;
        end
      end
      o.follow = cyclic_r && t.enabled;
    end else begin
      ramp_q12 = 0;
    end
    o.ref_int = 21'(floor_q12(ramp_q12));
    expected_refs.push_back(o);
  endfunction

  // Register write; only called while idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COEF:     coef_r = val[15:0];
      REG_POS_LIM:  pos_lim_r = val[14:0];
      REG_NEG_LIM:  neg_lim_r = val[15:0];
      REG_FREQ:     freq_r = val[15:0];
      REG_SLOPE:    slope_r = val;
      REG_OP_MODE:  cyclic_r = val[0];
      REG_POLARITY: polarity_r = val[0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] cf, logic [14:0] pl, logic [15:0] nl,
                           logic [15:0] fq, logic [31:0] sl, bit cy, bit po);
    write_reg(REG_COEF, 32'(cf));
    write_reg(REG_POS_LIM, 32'(pl));
    write_reg(REG_NEG_LIM, {16'h0, nl});
    write_reg(REG_FREQ, 32'(fq));
    write_reg(REG_SLOPE, sl);
    write_reg(REG_OP_MODE, 32'(cy));
    write_reg(REG_POLARITY, 32'(po));
  endtask

  // Offer one tick, with an optional idle burst first; leaves s_tvalid high
  task automatic send_tick(tick_t t);
    int gap;
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_tick(t);
  endtask

  task automatic end_burst();
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    end_burst();
    while (expected_refs.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic tick_t random_tick();
    tick_t t;
    t = 37'({$urandom, $urandom});
    // mostly a running, enabled drive so the ramp gets somewhere
    t.running = ($urandom_range(0, 9) != 0);
    t.enabled = ($urandom_range(0, 7) != 0);
    t.switching = ($urandom_range(0, 7) == 0);
    t.stop = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 2) != 0) begin
      t.target = $signed(16'($urandom_range(0, 1600))) - 16'sd800;
      t.offset = $signed(16'($urandom_range(0, 200))) - 16'sd100;
    end
    return t;
  endfunction

  // Directed: field extremes, flags and limit corner cases
  task automatic test_directed();
    tick_t t;
    write_all(16'd4096, 15'd3000, -16'sd3000, 16'd16000, 32'd0, 1'b0, 1'b0);
    t = '0; t.running = 1'b1; t.enabled = 1'b1; t.target = 16'sh7fff;
    send_tick(t); send_tick(t);
    t.target = 16'sh8000; send_tick(t);
    t.dirsel = 1'b1; send_tick(t);
    t.switching = 1'b1; send_tick(t);
    t.switching = 1'b0; t.stop = 1'b1; send_tick(t);
    t.running = 1'b0; send_tick(t);
    t.running = 1'b1; t.enabled = 1'b0; send_tick(t);
    t.enabled = 1'b1; t.target = 16'sd0; send_tick(t); send_tick(t);
    wait_drained();
    // zero frequency, positive negative limit, big slope, polarity, cyclic
    write_all(16'hffff, 15'h7fff, 16'sd5, 16'd0, 32'hffffffff, 1'b1, 1'b1);
    t = '0; t.running = 1'b1; t.enabled = 1'b1;
    t.target = 16'sh7fff; t.offset = 16'sh7fff; send_tick(t);
    t.target = 16'sh8000; t.offset = 16'sh8000; send_tick(t);
    t.dirsel = 1'b1; send_tick(t); send_tick(t);
    t.stop = 1'b1; send_tick(t);
    t.target = 16'sd3; t.offset = -16'sd1; t.stop = 1'b0; send_tick(t); send_tick(t);
    t.running = 1'b0; send_tick(t);
    wait_drained();
    write_all(16'd0, 15'd0, 16'sh8000, 16'hffff, 32'd1, 1'b0, 1'b0);
    t = '0; t.running = 1'b1; t.enabled = 1'b1; t.target = 16'sd100;
    send_tick(t); send_tick(t);
    wait_drained();
  endtask

  task automatic random_phase(int n);
    repeat (n) send_tick(random_tick());
    wait_drained();
  endtask

  // Random ticks under several register settings
  task automatic test_random();
    write_all(16'd4096, 15'd3000, -16'sd3000, 16'd16000, 32'd2000000, 1'b1, 1'b0);
    random_phase(120);
    write_all(16'd4096, 15'd2000, -16'sd2500, 16'd16000, 32'd500000, 1'b0, 1'b0);
    random_phase(80);
    for (int k = 0; k < 4; k++) begin
      write_all(16'($urandom), 15'($urandom), 16'($urandom),
                16'($urandom_range(1, 65535)),
                (($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 100000)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      random_phase(50);
    end
  endtask

  // Long receiver hold-off so the queue fills and s_tready drops
  task automatic test_backpressure();
    write_all(16'd4096, 15'd3000, -16'sd3000, 16'd16000, 32'd0, 1'b1, 1'b0);
    long_hold_req++;
    repeat (20) send_tick(random_tick());
    wait_drained();
  endtask

  // Last stretch without idling on either side
  task automatic test_full_rate();
    sender_idle_en = 0;
    receiver_idle_en = 0;
    write_all(16'd8192, 15'd32767, 16'sh8000, 16'd1, 32'd7, 1'b1, 1'b1);
    random_phase(100);
  endtask

  // Result checker
  always @(posedge clk) begin
    torque_out_t got, exp_o;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[21:0];
      if (expected_refs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %h", m_tdata);
      end else begin
        exp_o = expected_refs.pop_front();
        if (got.ref_int !== exp_o.ref_int || got.follow !== exp_o.follow ||
            m_tdata[23:22] !== 2'b00) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: torque_ref exp %0d got %0d, following exp %0b got %0b",
                     exp_o.ref_int, got.ref_int, exp_o.follow, got.follow);
        end
      end
    end
  end

  // Receiver: random stalls, plus a counted long hold-off on request
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b1;
    else if (long_hold_req != long_hold_seen) begin
      m_tready <= 1'b0;
      long_hold_seen <= long_hold_req;
      hold_off <= LONG_HOLD;
    end else if (hold_off > 0) begin
      m_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (receiver_idle_en && $urandom_range(0, 15) == 0) begin
      m_tready <= 1'b0;
      hold_off <= $urandom_range(0, 18);
    end else m_tready <= 1'b1;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    sender_idle_en = 1;
    receiver_idle_en = 1;
    coef_r = 16'd4096; pos_lim_r = 15'd3000; neg_lim_r = -16'sd3000;
    freq_r = 16'd16000; slope_r = 0; cyclic_r = 0; polarity_r = 0; ramp_q12 = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    test_full_rate();
    if (mismatches == 0 && expected_refs.size() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule

/* torque_command_ramp.f */
rtl/tcr_pkg.sv
rtl/tcr_fifo.sv
rtl/tcr_front.sv
rtl/tcr_div.sv
rtl/tcr_back.sv
rtl/torque_command_ramp.sv
rtl/tcr_checker.sv
test/testbench.sv
